// ----- rtl/i2r_pkg.sv -----
`timescale 1ns / 1ps

package i2r_pkg;

  localparam int MAX_THOUSANDS_DEF = 3;
  localparam int RESULT_LIMIT      = 15;
  localparam int VALUE_W           = 16;
  localparam int CHAR_W            = 7;

  typedef logic [3:0]         digit_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [1:0]         place_t;
  typedef logic [1:0]         sym_t;
  typedef logic [3:0]         count_t;

  typedef struct packed {
    digit_t th;
    digit_t hu;
    digit_t te;
    digit_t un;
  } digits_t;

  typedef struct packed {
    logic    done;
    digits_t digits;
  } du_stat_t;

  typedef struct packed {
    logic  busy;
    logic  valid;
    char_t char_code;
    logic  last;
  } em_stat_t;

  localparam place_t PL_TH = 2'd0;
  localparam place_t PL_HU = 2'd1;
  localparam place_t PL_TE = 2'd2;
  localparam place_t PL_UN = 2'd3;

  localparam sym_t SYM_ONE  = 2'd0;
  localparam sym_t SYM_FIVE = 2'd1;
  localparam sym_t SYM_TEN  = 2'd2;

  localparam char_t CH_NONE = 7'h00;
  localparam char_t CH_M    = 7'h4D;
  localparam char_t CH_D    = 7'h44;
  localparam char_t CH_C    = 7'h43;
  localparam char_t CH_L    = 7'h4C;
  localparam char_t CH_X    = 7'h58;
  localparam char_t CH_V    = 7'h56;
  localparam char_t CH_I    = 7'h49;

  function automatic logic [VALUE_W-1:0] place_weight(input place_t p);
    logic [VALUE_W-1:0] w;
    unique case (p)
      PL_TH:   w = 16'd1000;
      PL_HU:   w = 16'd100;
      PL_TE:   w = 16'd10;
      default: w = 16'd1;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] shape_len(input digit_t d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5:        n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:              n = 3'd2;
      4'd3, 4'd7:        n = 3'd3;
      4'd8:              n = 3'd4;
      default:           n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_t shape_sym(input digit_t d, input logic [1:0] pos);
    sym_t s;
    unique case (d)
      4'd4:                    s = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd5:                    s = SYM_FIVE;
      4'd6, 4'd7, 4'd8:        s = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
      4'd9:                    s = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
      default:                 s = SYM_ONE;
    endcase
    return s;
  endfunction

  function automatic char_t place_char(input place_t p, input sym_t s);
    char_t c;
    unique case (p)
      PL_HU:   c = (s == SYM_ONE) ? CH_C : ((s == SYM_FIVE) ? CH_D : CH_M);
      PL_TE:   c = (s == SYM_ONE) ? CH_X : ((s == SYM_FIVE) ? CH_L : CH_C);
      PL_UN:   c = (s == SYM_ONE) ? CH_I : ((s == SYM_FIVE) ? CH_V : CH_X);
      default: c = CH_M;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/i2r_digit_unit.sv -----
`timescale 1ns / 1ps

// Decimal digits by repeated subtraction through one shared subtractor.
module i2r_digit_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [i2r_pkg::VALUE_W-1:0]   value,
  output i2r_pkg::du_stat_t             stat
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  i2r_pkg::place_t               place_r, place_nxt;
  logic [i2r_pkg::VALUE_W-1:0]   rem_r, rem_nxt;
  i2r_pkg::digit_t               cnt_r, cnt_nxt;
  i2r_pkg::digit_t               th_r, hu_r, te_r;
  logic [i2r_pkg::VALUE_W:0]     diff;

  assign diff = {1'b0, rem_r} - {1'b0, i2r_pkg::place_weight(place_r)};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    place_nxt = place_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      busy_nxt  = 1'b1;
      place_nxt = i2r_pkg::PL_TH;
      rem_nxt   = value;
      cnt_nxt   = '0;
    end else if (busy_r) begin
      if (!diff[i2r_pkg::VALUE_W]) begin
        rem_nxt = diff[i2r_pkg::VALUE_W-1:0];
        cnt_nxt = cnt_r + 4'd1;
      end else begin
        cnt_nxt   = '0;
        place_nxt = place_r + 2'd1;
        if (place_r == i2r_pkg::PL_TE) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    place_r <= place_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    if (busy_r && diff[i2r_pkg::VALUE_W]) begin
      if (place_r == i2r_pkg::PL_TH) th_r <= cnt_r;
      if (place_r == i2r_pkg::PL_HU) hu_r <= cnt_r;
      if (place_r == i2r_pkg::PL_TE) te_r <= cnt_r;
    end
  end

  assign stat.done      = done_r;
  assign stat.digits.th = th_r;
  assign stat.digits.hu = hu_r;
  assign stat.digits.te = te_r;
  assign stat.digits.un = rem_r[3:0];

endmodule

// ----- rtl/i2r_emitter.sv -----
`timescale 1ns / 1ps

// Walks places and digit shapes, one letter per cycle except while it moves on to the next place.
module i2r_emitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  i2r_pkg::digits_t   digits,
  input  i2r_pkg::count_t    total,
  output i2r_pkg::em_stat_t  stat
);

  logic               busy_r, busy_nxt;
  logic               valid_r, valid_nxt;
  i2r_pkg::char_t     char_r, char_nxt;
  logic               last_r, last_nxt;
  i2r_pkg::place_t    place_r, place_nxt;
  logic [3:0]         pos_r, pos_nxt;
  i2r_pkg::count_t    remain_r, remain_nxt;
  i2r_pkg::digits_t   dig_r;
  i2r_pkg::digit_t    cur_dig;
  logic [3:0]         cur_len;

  always_comb begin
    unique case (place_r)
      i2r_pkg::PL_TH: cur_dig = dig_r.th;
      i2r_pkg::PL_HU: cur_dig = dig_r.hu;
      i2r_pkg::PL_TE: cur_dig = dig_r.te;
      default:        cur_dig = dig_r.un;
    endcase
    cur_len = (place_r == i2r_pkg::PL_TH) ? cur_dig : {1'b0, i2r_pkg::shape_len(cur_dig)};
  end

  always_comb begin
    busy_nxt   = busy_r;
    valid_nxt  = 1'b0;
    char_nxt   = char_r;
    last_nxt   = 1'b0;
    place_nxt  = place_r;
    pos_nxt    = pos_r;
    remain_nxt = remain_r;
    if (load) begin
      busy_nxt   = 1'b1;
      place_nxt  = i2r_pkg::PL_TH;
      pos_nxt    = '0;
      remain_nxt = total;
    end else if (busy_r) begin
      if (pos_r < cur_len) begin
        valid_nxt  = 1'b1;
        char_nxt   = i2r_pkg::place_char(place_r, i2r_pkg::shape_sym(cur_dig, pos_r[1:0]));
        pos_nxt    = pos_r + 4'd1;
        remain_nxt = remain_r - 4'd1;
        if (remain_r == 4'd1) begin
          last_nxt = 1'b1;
          busy_nxt = 1'b0;
        end
      end else begin
        place_nxt = place_r + 2'd1;
        pos_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
    char_r   <= char_nxt;
    last_r   <= last_nxt;
    place_r  <= place_nxt;
    pos_r    <= pos_nxt;
    remain_r <= remain_nxt;
    if (load) dig_r <= digits;
  end

  assign stat.busy      = busy_r;
  assign stat.valid     = valid_r;
  assign stat.char_code = char_r;
  assign stat.last      = last_r;

endmodule

// ----- rtl/integer_to_roman_numeral.sv -----
`timescale 1ns / 1ps

// Channel  Ports                                             Handshake
// in       in_value                                          start & !busy
// out      out_char_code out_is_last out_is_empty            out_strobe, one cycle
//          out_out_of_range
//
// Zero or above-limit item: one marker result the cycle after accept, busy stays low.
// Otherwise: digits by repeated subtraction through one subtractor, then a length check
// that turns a result of more than RESULT_LIMIT letters into an out-of-range marker; then
// one letter per cycle, held back at each change of place, the last one flagged.
// Synchronous active-low reset clears the sequencer; results cannot be stalled.
module integer_to_roman_numeral #(
  parameter int MAX_THOUSANDS = i2r_pkg::MAX_THOUSANDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [i2r_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_strobe,
  output logic [i2r_pkg::CHAR_W-1:0]    out_char_code,
  output logic                          out_is_last,
  output logic                          out_is_empty,
  output logic                          out_out_of_range
);

  localparam logic [i2r_pkg::VALUE_W-1:0] LIMIT =
    i2r_pkg::VALUE_W'(MAX_THOUSANDS * 1000 + 999);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LEN  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                mark_r, mark_nxt;
  logic                mark_empty_r, mark_empty_nxt;
  logic                mark_oor_r, mark_oor_nxt;
  logic                accept;
  logic                du_load, em_load;
  logic [4:0]          total;
  i2r_pkg::du_stat_t   du_stat;
  i2r_pkg::em_stat_t   em_stat;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  assign total = 5'(du_stat.digits.th)
               + 5'(i2r_pkg::shape_len(du_stat.digits.hu))
               + 5'(i2r_pkg::shape_len(du_stat.digits.te))
               + 5'(i2r_pkg::shape_len(du_stat.digits.un));

  always_comb begin
    state_nxt      = state_r;
    mark_nxt       = 1'b0;
    mark_empty_nxt = mark_empty_r;
    mark_oor_nxt   = mark_oor_r;
    du_load        = 1'b0;
    em_load        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_value == '0) begin
            mark_nxt       = 1'b1;
            mark_empty_nxt = 1'b1;
            mark_oor_nxt   = 1'b0;
          end else if (in_value > LIMIT) begin
            mark_nxt       = 1'b1;
            mark_empty_nxt = 1'b0;
            mark_oor_nxt   = 1'b1;
          end else begin
            du_load   = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (du_stat.done) state_nxt = ST_LEN;
      end
      ST_LEN: begin
        if (total > 5'(i2r_pkg::RESULT_LIMIT)) begin
          mark_nxt       = 1'b1;
          mark_empty_nxt = 1'b0;
          mark_oor_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          em_load   = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!em_stat.busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mark_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mark_r  <= mark_nxt;
    end
    mark_empty_r <= mark_empty_nxt;
    mark_oor_r   <= mark_oor_nxt;
  end

  i2r_digit_unit u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (du_load),
    .value (in_value),
    .stat  (du_stat)
  );

  i2r_emitter u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (em_load),
    .digits (du_stat.digits),
    .total  (total[3:0]),
    .stat   (em_stat)
  );

  assign out_strobe       = mark_r || em_stat.valid;
  assign out_char_code    = mark_r ? i2r_pkg::CH_NONE : em_stat.char_code;
  assign out_is_last      = mark_r || em_stat.last;
  assign out_is_empty     = mark_r && mark_empty_r;
  assign out_out_of_range = mark_r && mark_oor_r;

  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(mark_r && em_stat.valid))
    else $error("marker and letter results collide");

  a_zero_marker: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_value == '0) |=> out_strobe && out_is_empty && out_is_last)
    else $error("zero item did not give an empty marker");

  a_marker_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_is_empty || out_out_of_range) |->
      (out_char_code == i2r_pkg::CH_NONE) && out_is_last)
    else $error("marker result carries a letter");

  a_letter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    em_stat.valid && !em_stat.last |-> em_stat.busy && (state_r == ST_EMIT))
    else $error("letter run ended without a last flag");

endmodule

// ----- sim/tb_integer_to_roman_numeral.sv -----
`timescale 1ns / 1ps

module tb_integer_to_roman_numeral;

  localparam int THOUSANDS   = i2r_pkg::MAX_THOUSANDS_DEF;
  localparam int RANDOM_CNT  = 350;
  localparam int CALM_CNT    = 60;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    i2r_pkg::char_t code;
    logic           last;
    logic           empty;
    logic           oor;
  } letter_t;

  class numeral_board;
    letter_t pending_letters[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    // queue the letters one value spells, or its marker result
    function void note_value(input logic [i2r_pkg::VALUE_W-1:0] value);
      i2r_pkg::char_t ones[3];
      i2r_pkg::char_t fives[3];
      i2r_pkg::char_t tens[3];
      i2r_pkg::char_t spelled[$];
      int unsigned    v;
      int unsigned    d;
      letter_t        r;
      ones  = '{i2r_pkg::CH_C, i2r_pkg::CH_X, i2r_pkg::CH_I};
      fives = '{i2r_pkg::CH_D, i2r_pkg::CH_L, i2r_pkg::CH_V};
      tens  = '{i2r_pkg::CH_M, i2r_pkg::CH_C, i2r_pkg::CH_X};
      v = value;
      r = '0;
      r.code = i2r_pkg::CH_NONE;
      r.last = 1'b1;
      if (v == 0) begin
        r.empty = 1'b1;
        pending_letters.push_back(r);
        return;
      end
      if (v > THOUSANDS * 1000 + 999) begin
        r.oor = 1'b1;
        pending_letters.push_back(r);
        return;
      end
      for (int i = 0; i < v / 1000; i++) spelled.push_back(i2r_pkg::CH_M);
      v = v % 1000;
      for (int p = 0; p < 3; p++) begin
        d = (p == 0) ? v / 100 : ((p == 1) ? (v / 10) % 10 : v % 10);
        if (d == 9) begin
          spelled.push_back(ones[p]);
          spelled.push_back(tens[p]);
        end else if (d == 4) begin
          spelled.push_back(ones[p]);
          spelled.push_back(fives[p]);
        end else begin
          if (d >= 5) spelled.push_back(fives[p]);
          for (int i = 0; i < d % 5; i++) spelled.push_back(ones[p]);
        end
      end
      if (spelled.size() > i2r_pkg::RESULT_LIMIT) begin
        r.oor = 1'b1;
        pending_letters.push_back(r);
        return;
      end
      foreach (spelled[i]) begin
        r      = '0;
        r.code = spelled[i];
        r.last = (i == spelled.size() - 1);
        pending_letters.push_back(r);
      end
    endfunction

    function void check_letter(input letter_t got);
      letter_t want;
      if (pending_letters.size() == 0) begin
        $error("unexpected result: char_code %h last %b empty %b oor %b",
               got.code, got.last, got.empty, got.oor);
        errors++;
        return;
      end
      want = pending_letters.pop_front();
      if (got.code !== want.code) begin
        $error("char_code: expected %h, got %h", want.code, got.code);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("is_last: expected %b, got %b", want.last, got.last);
        errors++;
      end
      if (got.empty !== want.empty) begin
        $error("is_empty: expected %b, got %b", want.empty, got.empty);
        errors++;
      end
      if (got.oor !== want.oor) begin
        $error("out_of_range: expected %b, got %b", want.oor, got.oor);
        errors++;
      end
    endfunction

    function int pending();
      return pending_letters.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [i2r_pkg::VALUE_W-1:0] in_value;
  logic                        out_strobe;
  i2r_pkg::char_t              out_char_code;
  logic                        out_is_last;
  logic                        out_is_empty;
  logic                        out_out_of_range;

  numeral_board board;
  int           cycles = 0;

  logic [i2r_pkg::VALUE_W-1:0] directed [0:23] = '{
    16'd0, 16'd1, 16'd4, 16'd5, 16'd9, 16'd40, 16'd50, 16'd90, 16'd400,
    16'd500, 16'd900, 16'd1000, 16'd3, 16'd8, 16'd444, 16'd1994, 16'd3888,
    16'd3999, 16'd4000, 16'd65535, 16'd2047, 16'd3000, 16'd0, 16'd3999
  };

  integer_to_roman_numeral #(
    .MAX_THOUSANDS(THOUSANDS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_char_code   (out_char_code),
    .out_is_last     (out_is_last),
    .out_is_empty    (out_is_empty),
    .out_out_of_range(out_out_of_range)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      board.check_letter({out_char_code, out_is_last, out_is_empty, out_out_of_range});
    end
  end

  task automatic send_value(input logic [i2r_pkg::VALUE_W-1:0] value);
    @(negedge clk);
    start    = 1'b1;
    in_value = value;
    do @(posedge clk); while (busy);
    board.note_value(value);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start    = 1'b0;
      in_value = i2r_pkg::VALUE_W'($urandom);
    end
  endtask

  function automatic logic [i2r_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return i2r_pkg::VALUE_W'($urandom_range(4000, 65535));
    if (r < 20) return i2r_pkg::VALUE_W'($urandom);
    if (r < 30) return i2r_pkg::VALUE_W'($urandom_range(1, 99));
    return i2r_pkg::VALUE_W'($urandom_range(1, 3999));
  endfunction

  initial begin
    board    = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      send_value(directed[i]);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
    end

    for (int i = 0; i < RANDOM_CNT; i++) begin
      send_value(pick_value());
      // quiet stretches now and then, no gaps at all near the end
      if (i < RANDOM_CNT - CALM_CNT && (i / 40) % 3 != 2 && $urandom_range(0, 2) == 0)
        hold_off($urandom_range(1, 3));
    end
    hold_off(1);

    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/i2r_pkg.sv
rtl/i2r_digit_unit.sv
rtl/i2r_emitter.sv
rtl/integer_to_roman_numeral.sv
sim/tb_integer_to_roman_numeral.sv
